[hw/rtl/circle_box_overlap_direction_assert.svh]
// Assertion macros used by the checker file
`ifndef CIRCLE_BOX_OVERLAP_DIRECTION_ASSERT_SVH
`define CIRCLE_BOX_OVERLAP_DIRECTION_ASSERT_SVH

// Same-cycle implication, sampled on the rising clock edge
`define CBOD_ASSERT_NOW(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("cbod: same-cycle check failed");

// Next-cycle implication
`define CBOD_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("cbod: next-cycle check failed");

`endif

[hw/rtl/cbod_pkg.sv]
`default_nettype none
package cbod_pkg;

   // direction output, Q1.14
   localparam int DIR_W = 16;
   localparam logic [15:0] ONE_Q14 = 16'd16384;

   // normalised vector magnitudes and their squares
   localparam int MAG_W = 16;
   localparam int SQ_W  = 2 * MAG_W;
   localparam int DEN_W = SQ_W + 1;

   // quotient of a^2 * 2^30 / (a^2 + b^2), at most 2^30
   localparam int Q_W        = 31;
   localparam int DIV_STAGES = Q_W;

   // integer square root of the quotient, one result bit a stage
   localparam int ROOT_W      = 16;
   localparam int SQRT_STAGES = ROOT_W;
   localparam int REM_W       = ROOT_W + 2;

   // per-word flags carried alongside the arithmetic
   typedef struct packed {
      logic hit;
      logic neg_x;
      logic neg_y;
      logic zero;
   } flags_type;

endpackage
`default_nettype wire

[hw/rtl/circle_box_overlap_direction.sv]
// Pipeline: 4 front stages, 31 divide stages, 16 root stages and 1 output register.
// Throughput: one word per cycle; the whole pipeline holds while a result waits.
// The divider (one quotient bit a stage) sets the depth.
// Reset (synchronous, active high) clears every stage valid bit and the result valid.
`default_nettype none
module circle_box_overlap_direction #(
   parameter int COORD_WIDTH = 16
) (
   input  wire logic                        clock,
   input  wire logic                        reset,
   input  wire logic                        req_valid,
   output logic                             req_ready,
   input  wire logic [COORD_WIDTH-1:0]      req_circle_x,
   input  wire logic [COORD_WIDTH-1:0]      req_circle_y,
   input  wire logic [COORD_WIDTH-2:0]      req_circle_radius,
   input  wire logic [COORD_WIDTH-1:0]      req_box_x,
   input  wire logic [COORD_WIDTH-1:0]      req_box_y,
   input  wire logic [COORD_WIDTH-1:0]      req_box_width,
   input  wire logic [COORD_WIDTH-1:0]      req_box_height,
   output logic                             rsp_valid,
   input  wire logic                        rsp_ready,
   output logic                             rsp_hit,
   output logic signed [cbod_pkg::DIR_W-1:0] rsp_dir_x,
   output logic signed [cbod_pkg::DIR_W-1:0] rsp_dir_y
);

   logic adv;
   logic rsp_valid_ff;

   // pipeline moves whenever the result slot is free or being taken
   assign adv       = !rsp_valid_ff || rsp_ready;
   assign req_ready = adv;

   logic                       fr_valid;
   logic [cbod_pkg::SQ_W-1:0]  fr_a2, fr_b2;
   logic [cbod_pkg::DEN_W-1:0] fr_l2;
   cbod_pkg::flags_type        fr_flags;

   cbod_front #(.COORD_WIDTH(COORD_WIDTH)) u_front (
      .clock         (clock),
      .reset         (reset),
      .adv           (adv),
      .in_valid      (req_valid),
      .circle_x      (req_circle_x),
      .circle_y      (req_circle_y),
      .circle_radius (req_circle_radius),
      .box_x         (req_box_x),
      .box_y         (req_box_y),
      .box_width     (req_box_width),
      .box_height    (req_box_height),
      .out_valid     (fr_valid),
      .out_a2        (fr_a2),
      .out_b2        (fr_b2),
      .out_l2        (fr_l2),
      .out_flags     (fr_flags)
   );

   logic                     dv_valid;
   logic [cbod_pkg::Q_W-1:0] dv_qx, dv_qy;
   cbod_pkg::flags_type      dv_flags;

   cbod_div u_div (
      .clock     (clock),
      .reset     (reset),
      .adv       (adv),
      .in_valid  (fr_valid),
      .in_num_x  (fr_a2),
      .in_num_y  (fr_b2),
      .in_den    (fr_l2),
      .in_flags  (fr_flags),
      .out_valid (dv_valid),
      .out_q_x   (dv_qx),
      .out_q_y   (dv_qy),
      .out_flags (dv_flags)
   );

   logic                        sq_valid;
   logic [cbod_pkg::ROOT_W-1:0] sq_x, sq_y;
   cbod_pkg::flags_type         sq_flags;

   cbod_sqrt u_sqrt (
      .clock     (clock),
      .reset     (reset),
      .adv       (adv),
      .in_valid  (dv_valid),
      .in_x      (dv_qx),
      .in_y      (dv_qy),
      .in_flags  (dv_flags),
      .out_valid (sq_valid),
      .out_x     (sq_x),
      .out_y     (sq_y),
      .out_flags (sq_flags)
   );

   // largest odd t <= root gives magnitude (root + 1) / 2; apply sign
   logic [cbod_pkg::ROOT_W:0]  sumx, sumy;
   logic [cbod_pkg::DIR_W-1:0] magx, magy, dirx_in, diry_in;
   logic                       live;

   always_comb begin
      sumx    = {1'b0, sq_x} + 1'b1;
      sumy    = {1'b0, sq_y} + 1'b1;
      magx    = sumx[cbod_pkg::ROOT_W:1];
      magy    = sumy[cbod_pkg::ROOT_W:1];
      live    = sq_flags.hit && !sq_flags.zero;
      dirx_in = !live ? '0 : (sq_flags.neg_x ? (~magx + 1'b1) : magx);
      diry_in = !live ? '0 : (sq_flags.neg_y ? (~magy + 1'b1) : magy);
   end

   logic                       hit_ff;
   logic [cbod_pkg::DIR_W-1:0] dirx_ff, diry_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (adv) begin
         rsp_valid_ff <= sq_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         hit_ff  <= sq_flags.hit;
         dirx_ff <= dirx_in;
         diry_ff <= diry_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_hit   = hit_ff;
   assign rsp_dir_x = dirx_ff;
   assign rsp_dir_y = diry_ff;

endmodule
`default_nettype wire

[hw/rtl/cbod_front.sv]
`default_nettype none
// Geometry front end: gap to the box, hit test, vector normalisation and squares.
// Four register stages.
module cbod_front #(
   parameter int COORD_WIDTH = 16
) (
   input  wire logic                        clock,
   input  wire logic                        reset,
   input  wire logic                        adv,
   input  wire logic                        in_valid,
   input  wire logic [COORD_WIDTH-1:0]      circle_x,
   input  wire logic [COORD_WIDTH-1:0]      circle_y,
   input  wire logic [COORD_WIDTH-2:0]      circle_radius,
   input  wire logic [COORD_WIDTH-1:0]      box_x,
   input  wire logic [COORD_WIDTH-1:0]      box_y,
   input  wire logic [COORD_WIDTH-1:0]      box_width,
   input  wire logic [COORD_WIDTH-1:0]      box_height,
   output logic                             out_valid,
   output logic [cbod_pkg::SQ_W-1:0]        out_a2,
   output logic [cbod_pkg::SQ_W-1:0]        out_b2,
   output logic [cbod_pkg::DEN_W-1:0]       out_l2,
   output cbod_pkg::flags_type              out_flags
);

   localparam int CW = COORD_WIDTH;
   localparam int EW = CW + 3;
   localparam int MW = (CW > cbod_pkg::MAG_W) ? CW : cbod_pkg::MAG_W;
   localparam int KW = $clog2(MW);

   // ---------------- stage 1: doubled-coordinate gaps and centre difference
   logic [EW-1:0] c2x, c2y, b2x, b2y, lox, hix, loy, hiy, gx, gy;
   logic [CW:0]   vx, vy, ax, ay;
   logic [CW-1:0] rr;

   logic          s1_valid_ff;
   logic [CW-1:0] s1_gx_ff, s1_gy_ff, s1_rr_ff, s1_ma_ff, s1_mb_ff;
   logic          s1_ok_ff, s1_negx_ff, s1_negy_ff;
   logic          s1_ok_in;

   always_comb begin
      c2x = {{2{circle_x[CW-1]}}, circle_x, 1'b0};
      c2y = {{2{circle_y[CW-1]}}, circle_y, 1'b0};
      b2x = {{2{box_x[CW-1]}}, box_x, 1'b0};
      b2y = {{2{box_y[CW-1]}}, box_y, 1'b0};
      lox = b2x - {3'b000, box_width};
      hix = b2x + {3'b000, box_width};
      loy = b2y - {3'b000, box_height};
      hiy = b2y + {3'b000, box_height};
      if ($signed(c2x) < $signed(lox)) begin
         gx = lox - c2x;
      end else if ($signed(c2x) > $signed(hix)) begin
         gx = c2x - hix;
      end else begin
         gx = '0;
      end
      if ($signed(c2y) < $signed(loy)) begin
         gy = loy - c2y;
      end else if ($signed(c2y) > $signed(hiy)) begin
         gy = c2y - hiy;
      end else begin
         gy = '0;
      end
      rr       = {circle_radius, 1'b0};
      s1_ok_in = (gx < EW'(rr)) && (gy < EW'(rr));
      vx = {box_x[CW-1], box_x} - {circle_x[CW-1], circle_x};
      vy = {box_y[CW-1], box_y} - {circle_y[CW-1], circle_y};
      ax = vx[CW] ? (~vx + 1'b1) : vx;
      ay = vy[CW] ? (~vy + 1'b1) : vy;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (adv) begin
         s1_valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         s1_gx_ff   <= gx[CW-1:0];
         s1_gy_ff   <= gy[CW-1:0];
         s1_rr_ff   <= rr;
         s1_ok_ff   <= s1_ok_in;
         s1_ma_ff   <= ax[CW-1:0];
         s1_mb_ff   <= ay[CW-1:0];
         s1_negx_ff <= vx[CW];
         s1_negy_ff <= vy[CW];
      end
   end

   // ---------------- stage 2: squared gaps, normalising shift
   logic [2*CW-1:0] s2_sqgx_in, s2_sqgy_in, s2_sqrr_in;
   logic [MW-1:0]   ea, eb, eo;
   logic [KW-1:0]   shamt;
   logic [cbod_pkg::MAG_W-1:0] s2_an_in, s2_bn_in;

   logic                       s2_valid_ff, s2_ok_ff, s2_negx_ff, s2_negy_ff;
   logic [2*CW-1:0]            s2_sqgx_ff, s2_sqgy_ff, s2_sqrr_ff;
   logic [cbod_pkg::MAG_W-1:0] s2_an_ff, s2_bn_ff;

   always_comb begin
      s2_sqgx_in = {{CW{1'b0}}, s1_gx_ff} * {{CW{1'b0}}, s1_gx_ff};
      s2_sqgy_in = {{CW{1'b0}}, s1_gy_ff} * {{CW{1'b0}}, s1_gy_ff};
      s2_sqrr_in = {{CW{1'b0}}, s1_rr_ff} * {{CW{1'b0}}, s1_rr_ff};
      ea    = MW'(s1_ma_ff);
      eb    = MW'(s1_mb_ff);
      eo    = ea | eb;
      shamt = '0;
      // highest set bit above the 16-bit range decides the shift
      for (int i = cbod_pkg::MAG_W; i < MW; i++) begin
         if (eo[i]) begin
            shamt = KW'(i - cbod_pkg::MAG_W + 1);
         end
      end
      s2_an_in = cbod_pkg::MAG_W'(ea >> shamt);
      s2_bn_in = cbod_pkg::MAG_W'(eb >> shamt);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s2_valid_ff <= 1'b0;
      end else if (adv) begin
         s2_valid_ff <= s1_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         s2_sqgx_ff <= s2_sqgx_in;
         s2_sqgy_ff <= s2_sqgy_in;
         s2_sqrr_ff <= s2_sqrr_in;
         s2_ok_ff   <= s1_ok_ff;
         s2_an_ff   <= s2_an_in;
         s2_bn_ff   <= s2_bn_in;
         s2_negx_ff <= s1_negx_ff;
         s2_negy_ff <= s1_negy_ff;
      end
   end

   // ---------------- stage 3: strict hit compare, squared magnitudes
   logic [2*CW:0]            dist2;
   cbod_pkg::flags_type      s3_flags_in, s3_flags_ff;
   logic [cbod_pkg::SQ_W-1:0] s3_a2_in, s3_b2_in, s3_a2_ff, s3_b2_ff;
   logic                     s3_valid_ff;

   always_comb begin
      dist2             = {1'b0, s2_sqgx_ff} + {1'b0, s2_sqgy_ff};
      s3_flags_in.hit   = s2_ok_ff && (dist2 < {1'b0, s2_sqrr_ff});
      s3_flags_in.neg_x = s2_negx_ff;
      s3_flags_in.neg_y = s2_negy_ff;
      s3_flags_in.zero  = ((s2_an_ff | s2_bn_ff) == '0);
      s3_a2_in = {{cbod_pkg::MAG_W{1'b0}}, s2_an_ff} * {{cbod_pkg::MAG_W{1'b0}}, s2_an_ff};
      s3_b2_in = {{cbod_pkg::MAG_W{1'b0}}, s2_bn_ff} * {{cbod_pkg::MAG_W{1'b0}}, s2_bn_ff};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s3_valid_ff <= 1'b0;
      end else if (adv) begin
         s3_valid_ff <= s2_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         s3_flags_ff <= s3_flags_in;
         s3_a2_ff    <= s3_a2_in;
         s3_b2_ff    <= s3_b2_in;
      end
   end

   // ---------------- stage 4: squared length
   logic                       s4_valid_ff;
   logic [cbod_pkg::SQ_W-1:0]  s4_a2_ff, s4_b2_ff;
   logic [cbod_pkg::DEN_W-1:0] s4_l2_ff;
   cbod_pkg::flags_type        s4_flags_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s4_valid_ff <= 1'b0;
      end else if (adv) begin
         s4_valid_ff <= s3_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         s4_a2_ff    <= s3_a2_ff;
         s4_b2_ff    <= s3_b2_ff;
         s4_l2_ff    <= {1'b0, s3_a2_ff} + {1'b0, s3_b2_ff};
         s4_flags_ff <= s3_flags_ff;
      end
   end

   assign out_valid = s4_valid_ff;
   assign out_a2    = s4_a2_ff;
   assign out_b2    = s4_b2_ff;
   assign out_l2    = s4_l2_ff;
   assign out_flags = s4_flags_ff;

endmodule
`default_nettype wire

[hw/rtl/cbod_div.sv]
`default_nettype none
// Two-lane restoring divider, one quotient bit a stage, shared divisor.
// q = floor(num * 2^30 / den); num <= den is assumed, and the block does not enforce it.
module cbod_div (
   input  wire logic                             clock,
   input  wire logic                             reset,
   input  wire logic                             adv,
   input  wire logic                             in_valid,
   input  wire logic [cbod_pkg::SQ_W-1:0]        in_num_x,
   input  wire logic [cbod_pkg::SQ_W-1:0]        in_num_y,
   input  wire logic [cbod_pkg::DEN_W-1:0]       in_den,
   input  wire cbod_pkg::flags_type              in_flags,
   output logic                                  out_valid,
   output logic [cbod_pkg::Q_W-1:0]              out_q_x,
   output logic [cbod_pkg::Q_W-1:0]              out_q_y,
   output cbod_pkg::flags_type                   out_flags
);

   localparam int NS = cbod_pkg::DIV_STAGES;
   localparam int RW = cbod_pkg::DEN_W;
   localparam int QW = cbod_pkg::Q_W;

   logic                valid_ff [NS];
   logic [RW-1:0]       rx_ff    [NS];
   logic [RW-1:0]       ry_ff    [NS];
   logic [QW-1:0]       qx_ff    [NS];
   logic [QW-1:0]       qy_ff    [NS];
   logic [RW-1:0]       den_ff   [NS];
   cbod_pkg::flags_type flags_ff [NS];

   for (genvar s = 0; s < NS; s++) begin : g_stage
      logic                valid_prev;
      logic [RW-1:0]       rx_prev, ry_prev, den_prev, rx_in, ry_in;
      logic [QW-1:0]       qx_prev, qy_prev;
      logic                bx, by, gex, gey;
      logic [RW:0]         tx, ty;
      cbod_pkg::flags_type flags_prev;

      // first stage seeds the remainder with num / 2, next bit num[0]
      if (s == 0) begin : g_seed
         assign valid_prev = in_valid;
         assign rx_prev    = {2'b00, in_num_x[cbod_pkg::SQ_W-1:1]};
         assign ry_prev    = {2'b00, in_num_y[cbod_pkg::SQ_W-1:1]};
         assign qx_prev    = '0;
         assign qy_prev    = '0;
         assign bx         = in_num_x[0];
         assign by         = in_num_y[0];
         assign den_prev   = in_den;
         assign flags_prev = in_flags;
      end else begin : g_chain
         assign valid_prev = valid_ff[s-1];
         assign rx_prev    = rx_ff[s-1];
         assign ry_prev    = ry_ff[s-1];
         assign qx_prev    = qx_ff[s-1];
         assign qy_prev    = qy_ff[s-1];
         assign bx         = 1'b0;
         assign by         = 1'b0;
         assign den_prev   = den_ff[s-1];
         assign flags_prev = flags_ff[s-1];
      end

      // trial subtract, one per lane
      always_comb begin
         tx    = {rx_prev, bx};
         ty    = {ry_prev, by};
         gex   = (tx >= {1'b0, den_prev});
         gey   = (ty >= {1'b0, den_prev});
         rx_in = gex ? RW'(tx - {1'b0, den_prev}) : tx[RW-1:0];
         ry_in = gey ? RW'(ty - {1'b0, den_prev}) : ty[RW-1:0];
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            valid_ff[s] <= 1'b0;
         end else if (adv) begin
            valid_ff[s] <= valid_prev;
         end
      end

      always_ff @(posedge clock) begin
         if (adv) begin
            rx_ff[s]    <= rx_in;
            ry_ff[s]    <= ry_in;
            qx_ff[s]    <= {qx_prev[QW-2:0], gex};
            qy_ff[s]    <= {qy_prev[QW-2:0], gey};
            den_ff[s]   <= den_prev;
            flags_ff[s] <= flags_prev;
         end
      end
   end

   assign out_valid = valid_ff[NS-1];
   assign out_q_x   = qx_ff[NS-1];
   assign out_q_y   = qy_ff[NS-1];
   assign out_flags = flags_ff[NS-1];

endmodule
`default_nettype wire

[hw/rtl/cbod_sqrt.sv]
`default_nettype none
// Two-lane digit-by-digit integer square root, one root bit a stage.
module cbod_sqrt (
   input  wire logic                        clock,
   input  wire logic                        reset,
   input  wire logic                        adv,
   input  wire logic                        in_valid,
   input  wire logic [cbod_pkg::Q_W-1:0]    in_x,
   input  wire logic [cbod_pkg::Q_W-1:0]    in_y,
   input  wire cbod_pkg::flags_type         in_flags,
   output logic                             out_valid,
   output logic [cbod_pkg::ROOT_W-1:0]      out_x,
   output logic [cbod_pkg::ROOT_W-1:0]      out_y,
   output cbod_pkg::flags_type              out_flags
);

   localparam int NS = cbod_pkg::SQRT_STAGES;
   localparam int RW = cbod_pkg::REM_W;
   localparam int OW = cbod_pkg::ROOT_W;
   localparam int VW = 2 * OW;

   logic                valid_ff [NS];
   logic [RW-1:0]       remx_ff  [NS];
   logic [RW-1:0]       remy_ff  [NS];
   logic [OW-1:0]       rootx_ff [NS];
   logic [OW-1:0]       rooty_ff [NS];
   logic [VW-1:0]       vx_ff    [NS];
   logic [VW-1:0]       vy_ff    [NS];
   cbod_pkg::flags_type flags_ff [NS];

   for (genvar s = 0; s < NS; s++) begin : g_stage
      logic                valid_prev;
      logic [RW-1:0]       remx_prev, remy_prev;
      logic [OW-1:0]       rootx_prev, rooty_prev;
      logic [VW-1:0]       vx_prev, vy_prev;
      cbod_pkg::flags_type flags_prev;
      logic [RW+1:0]       tx, ty, trx, try_v;
      logic                gex, gey;

      if (s == 0) begin : g_seed
         assign valid_prev = in_valid;
         assign remx_prev  = '0;
         assign remy_prev  = '0;
         assign rootx_prev = '0;
         assign rooty_prev = '0;
         assign vx_prev    = VW'(in_x);
         assign vy_prev    = VW'(in_y);
         assign flags_prev = in_flags;
      end else begin : g_chain
         assign valid_prev = valid_ff[s-1];
         assign remx_prev  = remx_ff[s-1];
         assign remy_prev  = remy_ff[s-1];
         assign rootx_prev = rootx_ff[s-1];
         assign rooty_prev = rooty_ff[s-1];
         assign vx_prev    = vx_ff[s-1];
         assign vy_prev    = vy_ff[s-1];
         assign flags_prev = flags_ff[s-1];
      end

      // bring down the next two bits and try root*4 + 1
      always_comb begin
         tx    = {remx_prev, vx_prev[VW-1:VW-2]};
         ty    = {remy_prev, vy_prev[VW-1:VW-2]};
         trx   = (RW+2)'({rootx_prev, 2'b01});
         try_v = (RW+2)'({rooty_prev, 2'b01});
         gex   = (tx >= trx);
         gey   = (ty >= try_v);
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            valid_ff[s] <= 1'b0;
         end else if (adv) begin
            valid_ff[s] <= valid_prev;
         end
      end

      always_ff @(posedge clock) begin
         if (adv) begin
            remx_ff[s]  <= gex ? RW'(tx - trx) : tx[RW-1:0];
            remy_ff[s]  <= gey ? RW'(ty - try_v) : ty[RW-1:0];
            rootx_ff[s] <= {rootx_prev[OW-2:0], gex};
            rooty_ff[s] <= {rooty_prev[OW-2:0], gey};
            vx_ff[s]    <= {vx_prev[VW-3:0], 2'b00};
            vy_ff[s]    <= {vy_prev[VW-3:0], 2'b00};
            flags_ff[s] <= flags_prev;
         end
      end
   end

   assign out_valid = valid_ff[NS-1];
   assign out_x     = rootx_ff[NS-1];
   assign out_y     = rooty_ff[NS-1];
   assign out_flags = flags_ff[NS-1];

endmodule
`default_nettype wire

[hw/rtl/cbod_checker.sv]
`default_nettype none
`include "circle_box_overlap_direction_assert.svh"
// Port-level checks on the result channel and on input ready
module cbod_checker (
   input wire logic                        clock,
   input wire logic                        reset,
   input wire logic                        req_ready,
   input wire logic                        rsp_valid,
   input wire logic                        rsp_ready,
   input wire logic                        rsp_hit,
   input wire logic signed [cbod_pkg::DIR_W-1:0] rsp_dir_x,
   input wire logic signed [cbod_pkg::DIR_W-1:0] rsp_dir_y
);

   logic signed [cbod_pkg::DIR_W-1:0] one_q14;
   logic                              dir_zero, dir_in_range;

   always_comb begin
      one_q14      = $signed(cbod_pkg::ONE_Q14);
      dir_zero     = (rsp_dir_x == '0) && (rsp_dir_y == '0);
      dir_in_range = (rsp_dir_x <= one_q14) && (rsp_dir_x >= -one_q14)
                     && (rsp_dir_y <= one_q14) && (rsp_dir_y >= -one_q14);
   end

   // a stalled result word stays offered
   `CBOD_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready, rsp_valid)

   // input is open whenever no result word waits
   `CBOD_ASSERT_NOW(a_req_open, clock, reset, !rsp_valid, req_ready)

   // a miss carries a zero vector
   `CBOD_ASSERT_NOW(a_miss_zero, clock, reset, rsp_valid && !rsp_hit, dir_zero)

   // components never exceed one in Q1.14
   `CBOD_ASSERT_NOW(a_dir_range, clock, reset, rsp_valid, dir_in_range)

endmodule

bind circle_box_overlap_direction cbod_checker u_cbod_checker (.*);
`default_nettype wire

[tb/sv/circle_box_overlap_direction_tb.sv]
`default_nettype none
module circle_box_overlap_direction_tb;

   localparam int CW          = 16;
   localparam int LATENCY     = 52;
   localparam int N_RANDOM    = 930;
   localparam int IDLE_LIMIT  = 20000;
   localparam int HOLD_CYCLES = 300;

   logic clock = 1'b0;
   logic reset = 1'b1;

   logic                              req_valid = 1'b0;
   logic                              req_ready;
   logic [CW-1:0]                     req_circle_x = '0;
   logic [CW-1:0]                     req_circle_y = '0;
   logic [CW-2:0]                     req_circle_radius = '0;
   logic [CW-1:0]                     req_box_x = '0;
   logic [CW-1:0]                     req_box_y = '0;
   logic [CW-1:0]                     req_box_width = '0;
   logic [CW-1:0]                     req_box_height = '0;
   logic                              rsp_valid;
   logic                              rsp_ready = 1'b0;
   logic                              rsp_hit;
   logic signed [cbod_pkg::DIR_W-1:0] rsp_dir_x;
   logic signed [cbod_pkg::DIR_W-1:0] rsp_dir_y;

   typedef struct packed {
      logic [CW-1:0] cx;
      logic [CW-1:0] cy;
      logic [CW-2:0] r;
      logic [CW-1:0] bx;
      logic [CW-1:0] by;
      logic [CW-1:0] w;
      logic [CW-1:0] h;
   } query_type;

   typedef struct packed {
      logic                       hit;
      logic [cbod_pkg::DIR_W-1:0] dx;
      logic [cbod_pkg::DIR_W-1:0] dy;
   } contact_type;

   contact_type contact_q[$];
   int          n_errors = 0;
   bit          stim_done = 1'b0;
   bit          hold_req = 1'b0;
   bit          hold_done = 1'b0;

   circle_box_overlap_direction #(.COORD_WIDTH(CW)) i_dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready),
      .req_circle_x(req_circle_x), .req_circle_y(req_circle_y),
      .req_circle_radius(req_circle_radius),
      .req_box_x(req_box_x), .req_box_y(req_box_y),
      .req_box_width(req_box_width), .req_box_height(req_box_height),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready),
      .rsp_hit(rsp_hit), .rsp_dir_x(rsp_dir_x), .rsp_dir_y(rsp_dir_y)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   // distance from doubled centre to an interval, doubled units
   function automatic longint unsigned edge_gap(longint c2, longint lo, longint hi);
      if (c2 < lo) return lo - c2;
      if (c2 > hi) return c2 - hi;
      return 0;
   endfunction

   // exact round(16384 * a / |(a,b)|) by bisection
   function automatic longint unsigned norm_component(longint unsigned a,
                                                      longint unsigned b);
      longint unsigned len2, lhs, lo, hi, mid, t;
      len2 = a * a + b * b;
      lhs  = (a * a) << 30;
      lo = 0;
      hi = 16384;
      if (a == 0) return 0;
      while (lo < hi) begin
         mid = (lo + hi + 1) / 2;
         t = 2 * mid - 1;
         if (lhs >= t * t * len2) lo = mid;
         else hi = mid - 1;
      end
      return lo;
   endfunction

   function automatic contact_type predict_contact(query_type q);
      longint cx, cy, bx, by, w, h, vx, vy;
      longint unsigned gx, gy, rr, a, b, m;
      contact_type res;
      cx = longint'($signed(q.cx));
      cy = longint'($signed(q.cy));
      bx = longint'($signed(q.bx));
      by = longint'($signed(q.by));
      w  = longint'(q.w);
      h  = longint'(q.h);
      gx = edge_gap(2 * cx, 2 * bx - w, 2 * bx + w);
      gy = edge_gap(2 * cy, 2 * by - h, 2 * by + h);
      rr = 2 * longint'(q.r);
      res = '0;
      if (gx < rr && gy < rr) res.hit = (gx * gx) < (rr * rr - gy * gy);
      if (res.hit) begin
         vx = bx - cx;
         vy = by - cy;
         a = vx < 0 ? -vx : vx;
         b = vy < 0 ? -vy : vy;
         while (a >= 65536 || b >= 65536) begin
            a >>= 1;
            b >>= 1;
         end
         m = norm_component(a, b);
         res.dx = vx < 0 ? cbod_pkg::DIR_W'(17'h10000 - m) : cbod_pkg::DIR_W'(m);
         m = norm_component(b, a);
         res.dy = vy < 0 ? cbod_pkg::DIR_W'(17'h10000 - m) : cbod_pkg::DIR_W'(m);
      end
      return res;
   endfunction

   task automatic report_mismatch(string what, longint got, longint want);
      $display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $time);
      n_errors++;
   endtask

   // offer one word, hold until accepted
   task automatic send_query(query_type q);
      @(negedge clock);
      req_valid         <= 1'b1;
      req_circle_x      <= q.cx;
      req_circle_y      <= q.cy;
      req_circle_radius <= q.r;
      req_box_x         <= q.bx;
      req_box_y         <= q.by;
      req_box_width     <= q.w;
      req_box_height    <= q.h;
      do @(posedge clock); while (!req_ready);
      contact_q.push_back(predict_contact(q));
   endtask

   task automatic drop_valid();
      @(negedge clock);
      req_valid <= 1'b0;
   endtask

   function automatic logic [CW-1:0] rnd_coord();
      case ($urandom_range(0, 5))
         0: return CW'(16'h8000);
         1: return CW'(16'h7fff);
         default: return CW'($urandom);
      endcase
   endfunction

   // mostly near geometry so hits are common
   function automatic query_type rnd_query();
      query_type q;
      int sel;
      sel = $urandom_range(0, 9);
      q.cx = rnd_coord();
      q.cy = rnd_coord();
      q.r  = (CW-1)'($urandom);
      q.w  = CW'($urandom);
      q.h  = CW'($urandom);
      if (sel < 7) begin
         q.bx = q.cx + CW'($signed($urandom_range(0, 2000)) - 1000);
         q.by = q.cy + CW'($signed($urandom_range(0, 2000)) - 1000);
         q.r  = (CW-1)'($urandom_range(0, 1200));
         q.w  = CW'($urandom_range(0, 800));
         q.h  = CW'($urandom_range(0, 800));
         if (sel == 0) begin
            q.bx = q.cx;
            q.by = q.cy;
         end
      end else begin
         q.bx = rnd_coord();
         q.by = rnd_coord();
      end
      return q;
   endfunction

   // directed rows; expectation typed only where obvious
   typedef struct {
      query_type   q;
      bit          fixed;
      contact_type want;
   } row_type;

   row_type rows[$];

   task automatic add_row(logic [CW-1:0] cx, logic [CW-1:0] cy, logic [CW-2:0] r,
                          logic [CW-1:0] bx, logic [CW-1:0] by, logic [CW-1:0] w,
                          logic [CW-1:0] h, bit fixed, contact_type want);
      row_type row;
      row.q = '{cx, cy, r, bx, by, w, h};
      row.fixed = fixed;
      row.want = want;
      rows.push_back(row);
   endtask

   // stimulus
   initial begin
      int burst;
      repeat (8) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // zero radius never hits
      add_row(0, 0, 0, 0, 0, 0, 0, 1, '0);
      add_row(0, 0, 0, 0, 0, 16'hffff, 16'hffff, 1, '0);
      // coincident centres on a hit: zero vector, hit set
      add_row(100, 100, 10, 100, 100, 4, 4, 1, '{1'b1, 16'd0, 16'd0});
      add_row(16'h8000, 16'h8000, 15'h7fff, 16'h8000, 16'h8000, 0, 0, 1,
              '{1'b1, 16'd0, 16'd0});
      // axis directions
      add_row(0, 0, 100, 50, 0, 0, 0, 1, '{1'b1, 16'd16384, 16'd0});
      add_row(0, 0, 100, 16'hffce, 0, 0, 0, 1, '{1'b1, 16'hc000, 16'd0});
      add_row(0, 0, 100, 0, 50, 0, 0, 1, '{1'b1, 16'd0, 16'd16384});
      add_row(0, 0, 100, 0, 16'hffce, 0, 0, 1, '{1'b1, 16'd0, 16'hc000});
      // far apart, no hit
      add_row(16'h8000, 16'h8000, 1, 16'h7fff, 16'h7fff, 0, 0, 1, '0);
      // strict edge: distance equals radius, then radius one larger
      add_row(0, 0, 10, 10, 0, 0, 0, 0, '0);
      add_row(0, 0, 11, 10, 0, 0, 0, 0, '0);
      // extremes and mixed cases, checked by the predictor
      add_row(16'h8000, 16'h7fff, 15'h7fff, 16'h7fff, 16'h8000, 16'hffff, 16'hffff, 0, '0);
      add_row(16'h7fff, 16'h8000, 15'h7fff, 16'h8000, 16'h7fff, 16'hffff, 16'hffff, 0, '0);
      add_row(16'h8000, 16'h8000, 15'h7fff, 16'h7fff, 16'h7fff, 16'hffff, 16'hffff, 0, '0);
      add_row(16'h5555, 16'haaaa, 15'h2aaa, 16'haaaa, 16'h5555, 16'h5555, 16'haaaa, 0, '0);
      add_row(16'haaaa, 16'h5555, 15'h5555, 16'h5555, 16'haaaa, 16'haaaa, 16'h5555, 0, '0);
      add_row(0, 0, 30, 20, 20, 4, 4, 0, '0);
      add_row(0, 0, 30, 16'hffec, 16'hffec, 4, 4, 0, '0);
      add_row(3, 7, 200, 100, 40, 300, 10, 0, '0);

      foreach (rows[i]) begin
         send_query(rows[i].q);
         if (rows[i].fixed && predict_contact(rows[i].q) != rows[i].want)
            report_mismatch("directed table row", i, 0);
         if ($urandom_range(0, 3) == 0) drop_valid();
      end
      drop_valid();

      // pause until drained
      while (contact_q.size() != 0) @(posedge clock);

      // long receiver hold-off while offering words back to back
      hold_req = 1'b1;
      for (int i = 0; i < 150; i++) send_query(rnd_query());

      // bursts with random gaps
      for (int n = 0; n < N_RANDOM; ) begin
         burst = $urandom_range(1, 40);
         for (int k = 0; k < burst; k++) begin
            send_query(rnd_query());
            n++;
         end
         drop_valid();
         if ($urandom_range(0, 2) != 0) repeat ($urandom_range(1, 12)) @(negedge clock);
      end
      stim_done = 1'b1;
   end

   // receiver: stall pattern of its own, plus one long hold-off counted here
   initial begin
      int phase;
      phase = 0;
      forever begin
         @(negedge clock);
         phase++;
         if (hold_req && !hold_done) begin
            rsp_ready <= 1'b0;
            repeat (HOLD_CYCLES) @(negedge clock);
            hold_done = 1'b1;
         end
         if ((phase % 700) < 200) rsp_ready <= 1'b1;
         else rsp_ready <= ($urandom_range(0, 3) != 0);
      end
   end

   // result checker
   always @(posedge clock) begin
      contact_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (contact_q.size() == 0) begin
            report_mismatch("word with none expected", rsp_hit, 0);
         end else begin
            want = contact_q.pop_front();
            if (rsp_hit !== want.hit) report_mismatch("hit", rsp_hit, want.hit);
            if (rsp_dir_x !== want.dx)
               report_mismatch("dir_x", rsp_dir_x, $signed(want.dx));
            if (rsp_dir_y !== want.dy)
               report_mismatch("dir_y", rsp_dir_y, $signed(want.dy));
         end
      end
   end

   // end of run and watchdog
   initial begin
      int idle;
      idle = 0;
      forever begin
         @(posedge clock);
         if ((req_valid && req_ready) || (rsp_valid && rsp_ready)) idle = 0;
         else idle++;
         if (idle >= IDLE_LIMIT) begin
            $display("timeout, %0d words outstanding", contact_q.size());
            $display("== FAIL ==");
            $finish;
         end
         if (stim_done && contact_q.size() == 0) begin
            repeat (LATENCY + 10) @(posedge clock);
            if (n_errors == 0) begin
               $display("== PASS ==");
            end else begin
               $display("== FAIL ==");
            end
            $finish;
         end
      end
   end

endmodule
`default_nettype wire
